// ===== sv/c2s_pkg.sv =====
// shared constants, types and the arctangent table of the cartesian to spherical converter
package c2s_pkg;

	localparam int CORDIC_STAGES = 32;
	localparam int COORD_WIDTH   = 32;
	localparam int FRAC_SHIFT    = 61 - COORD_WIDTH;
	localparam int WIDE_W        = 64;
	localparam int ANGLE_W       = 32;
	localparam int POLAR_W       = 31;
	localparam int ATAN_ENTRIES  = 32;
	localparam int GAIN_W        = 31;
	localparam int PROD_W        = 63;
	// cycles from the input transfer edge to the edge that ends the result strobe
	localparam int LATENCY       = 2 * CORDIC_STAGES + 6;

	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic        [ANGLE_W-1:0] angle_t;
	typedef logic        [PROD_W-1:0]  prod_t;

	localparam logic [GAIN_W-1:0] INV_GAIN     = 31'd1304065748;
	localparam angle_t            QUARTER_TURN = 32'h4000_0000;
	localparam angle_t            HALF_TURN    = 32'h8000_0000;
	localparam angle_t            NEG_QUARTER  = 32'hC000_0000;
	localparam logic [POLAR_W-1:0] POLAR_MAX   = '1;

	localparam angle_t ATAN_TAB [ATAN_ENTRIES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
	};

	// arctangent step of one iteration, zero past the end of the table
	function automatic angle_t atan_step(input int idx);
		angle_t res;
		res = '0;
		if (idx < ATAN_ENTRIES) begin
			res = ATAN_TAB[idx[4:0]];
		end
		return res;
	endfunction

endpackage

// ===== sv/cartesian_to_spherical.sv =====
// cartesian to spherical converter: two pipelined cordic vectoring passes
//
// usage
//   a point transfer happens at a rising edge with start high and busy low.
//   busy is always low: the pipeline takes one point in every cycle.
//   each result is shown on azimuth, polar_angle and radius for one cycle,
//   marked by done, and is taken at the edge that ends that cycle.
// throughput and depth
//   one point per cycle. before its strobe, a point passes through one input
//   stage, CORDIC_STAGES iteration stages per pass, two gain stages after
//   pass one, a pre-rotation stage before pass two, and a gain stage and
//   output stage after it.
//   the iteration chains, one shift-add stage each, set the depth.
// reset
//   arst_n clears all valid bits at once; no result is shown afterwards until
//   a new point goes through. payload registers are not reset.
// stall
//   the receiver cannot hold results off, so nothing in the pipeline stalls.
module cartesian_to_spherical import c2s_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	input  logic signed [COORD_WIDTH-1:0] z_coord,
	output logic                          done,
	output logic signed [ANGLE_W-1:0]     azimuth,
	output logic        [POLAR_W-1:0]     polar_angle,
	output logic        [COORD_WIDTH-1:0] radius
);

	localparam int N = CORDIC_STAGES;

	// pass one pipeline, index 0 is the input stage
	logic   p1_v_s   [0:N];
	wide_t  p1_x_s   [0:N];
	wide_t  p1_y_s   [0:N];
	angle_t p1_a_s   [0:N];
	wide_t  p1_z_s   [0:N];
	logic   p1_xy0_s [0:N];
	logic   p1_org_s [0:N];

	// pass two pipeline, index 0 is the pre-rotation stage
	logic   p2_v_s   [0:N];
	wide_t  p2_x_s   [0:N];
	wide_t  p2_y_s   [0:N];
	angle_t p2_a_s   [0:N];
	angle_t p2_az_s  [0:N];
	logic   p2_org_s [0:N];

	assign busy = 1'b0;

	// input stage: sign extend, scale to guard bits, turn into the right half plane
	wide_t xin, yin, zin;
	assign xin = wide_t'({{(WIDE_W-COORD_WIDTH){x_coord[COORD_WIDTH-1]}}, x_coord}) <<< FRAC_SHIFT;
	assign yin = wide_t'({{(WIDE_W-COORD_WIDTH){y_coord[COORD_WIDTH-1]}}, y_coord}) <<< FRAC_SHIFT;
	assign zin = wide_t'({{(WIDE_W-COORD_WIDTH){z_coord[COORD_WIDTH-1]}}, z_coord}) <<< FRAC_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p1_v_s[0] <= 1'b0;
		end else begin
			p1_v_s[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (xin < 0) begin
			if (yin >= 0) begin
				p1_x_s[0] <= yin;
				p1_y_s[0] <= -xin;
				p1_a_s[0] <= QUARTER_TURN;
			end else begin
				p1_x_s[0] <= -yin;
				p1_y_s[0] <= xin;
				p1_a_s[0] <= NEG_QUARTER;
			end
		end else begin
			p1_x_s[0] <= xin;
			p1_y_s[0] <= yin;
			p1_a_s[0] <= '0;
		end
		p1_z_s[0]   <= zin;
		p1_xy0_s[0] <= (x_coord == '0) && (y_coord == '0);
		p1_org_s[0] <= (x_coord == '0) && (y_coord == '0) && (z_coord == '0);
	end

	// iteration stages of both passes
	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				p1_v_s[i+1] <= 1'b0;
				p2_v_s[i+1] <= 1'b0;
			end else begin
				p1_v_s[i+1] <= p1_v_s[i];
				p2_v_s[i+1] <= p2_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (p1_y_s[i] >= 0) begin
				p1_x_s[i+1] <= p1_x_s[i] + (p1_y_s[i] >>> i);
				p1_y_s[i+1] <= p1_y_s[i] - (p1_x_s[i] >>> i);
				p1_a_s[i+1] <= p1_a_s[i] + atan_step(i);
			end else begin
				p1_x_s[i+1] <= p1_x_s[i] - (p1_y_s[i] >>> i);
				p1_y_s[i+1] <= p1_y_s[i] + (p1_x_s[i] >>> i);
				p1_a_s[i+1] <= p1_a_s[i] - atan_step(i);
			end
			p1_z_s[i+1]   <= p1_z_s[i];
			p1_xy0_s[i+1] <= p1_xy0_s[i];
			p1_org_s[i+1] <= p1_org_s[i];

			if (p2_y_s[i] >= 0) begin
				p2_x_s[i+1] <= p2_x_s[i] + (p2_y_s[i] >>> i);
				p2_y_s[i+1] <= p2_y_s[i] - (p2_x_s[i] >>> i);
				p2_a_s[i+1] <= p2_a_s[i] + atan_step(i);
			end else begin
				p2_x_s[i+1] <= p2_x_s[i] - (p2_y_s[i] >>> i);
				p2_y_s[i+1] <= p2_y_s[i] + (p2_x_s[i] >>> i);
				p2_a_s[i+1] <= p2_a_s[i] - atan_step(i);
			end
			p2_az_s[i+1]  <= p2_az_s[i];
			p2_org_s[i+1] <= p2_org_s[i];
		end
	end

	// gain stage one of pass one: two partial products of the clamped magnitude
	logic  g1_v_s, g2_v_s, g3_v_s;
	prod_t g1_hi_s, g1_lo_s;
	wide_t g1_z_s;
	angle_t g1_az_s;
	logic  g1_xy0_s, g1_org_s;
	wide_t ua1;
	assign ua1 = (p1_x_s[N] < 0) ? wide_t'(0) : p1_x_s[N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g1_v_s    <= 1'b0;
			g2_v_s    <= 1'b0;
			p2_v_s[0] <= 1'b0;
			g3_v_s    <= 1'b0;
			done      <= 1'b0;
		end else begin
			g1_v_s    <= p1_v_s[N];
			g2_v_s    <= g1_v_s;
			p2_v_s[0] <= g2_v_s;
			g3_v_s    <= p2_v_s[N];
			done      <= g3_v_s;
		end
	end

	always_ff @(posedge clk) begin
		g1_hi_s  <= prod_t'(ua1[WIDE_W-1:32]) * prod_t'(INV_GAIN);
		g1_lo_s  <= prod_t'(ua1[31:0]) * prod_t'(INV_GAIN);
		g1_z_s   <= p1_z_s[N];
		g1_az_s  <= p1_a_s[N];
		g1_xy0_s <= p1_xy0_s[N];
		g1_org_s <= p1_org_s[N];
	end

	// gain stage two of pass one: sum into rho, zero for a point on the z axis
	wide_t g2_rho_s, g2_z_s;
	angle_t g2_az_s;
	logic  g2_org_s;
	always_ff @(posedge clk) begin
		if (g1_xy0_s) begin
			g2_rho_s <= '0;
			g2_az_s  <= '0;
		end else begin
			g2_rho_s <= wide_t'({g1_hi_s, 1'b0}) + wide_t'(g1_lo_s[62:31]);
			g2_az_s  <= g1_az_s;
		end
		g2_z_s   <= g1_z_s;
		g2_org_s <= g1_org_s;
	end

	// pre-rotation of pass two, (z, rho) into the right half plane
	always_ff @(posedge clk) begin
		if (g2_z_s < 0) begin
			if (g2_rho_s >= 0) begin
				p2_x_s[0] <= g2_rho_s;
				p2_y_s[0] <= -g2_z_s;
				p2_a_s[0] <= QUARTER_TURN;
			end else begin
				p2_x_s[0] <= -g2_rho_s;
				p2_y_s[0] <= g2_z_s;
				p2_a_s[0] <= NEG_QUARTER;
			end
		end else begin
			p2_x_s[0] <= g2_z_s;
			p2_y_s[0] <= g2_rho_s;
			p2_a_s[0] <= '0;
		end
		p2_az_s[0]  <= g2_az_s;
		p2_org_s[0] <= g2_org_s;
	end

	// gain stage of pass two: partial products of the length
	prod_t g3_hi_s, g3_lo_s;
	angle_t g3_pol_s, g3_az_s;
	logic  g3_org_s;
	wide_t ua2;
	assign ua2 = (p2_x_s[N] < 0) ? wide_t'(0) : p2_x_s[N];

	always_ff @(posedge clk) begin
		g3_hi_s  <= prod_t'(ua2[WIDE_W-1:32]) * prod_t'(INV_GAIN);
		g3_lo_s  <= prod_t'(ua2[31:0]) * prod_t'(INV_GAIN);
		g3_pol_s <= p2_a_s[N];
		g3_az_s  <= p2_az_s[N];
		g3_org_s <= p2_org_s[N];
	end

	// output stage: round the radius, saturate, clamp the polar angle
	logic [WIDE_W-1:0] rint, rrnd, rsh;
	assign rint = {g3_hi_s, 1'b0} + WIDE_W'(g3_lo_s[62:31]);
	assign rrnd = rint + (WIDE_W'(1) << (FRAC_SHIFT - 1));
	assign rsh  = rrnd >> FRAC_SHIFT;

	always_ff @(posedge clk) begin
		if (g3_org_s) begin
			azimuth     <= '0;
			polar_angle <= '0;
			radius      <= '0;
		end else begin
			azimuth <= g3_az_s;
			if (g3_pol_s >= NEG_QUARTER) begin
				polar_angle <= '0;
			end else if (g3_pol_s >= HALF_TURN) begin
				polar_angle <= POLAR_MAX;
			end else begin
				polar_angle <= g3_pol_s[POLAR_W-1:0];
			end
			if (rsh[WIDE_W-1:COORD_WIDTH] != '0) begin
				radius <= '1;
			end else begin
				radius <= rsh[COORD_WIDTH-1:0];
			end
		end
	end

endmodule

// ===== sv/c2s_checker.sv =====
// port-level checker of the cartesian to spherical converter and its bind
module c2s_checker import c2s_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic signed [COORD_WIDTH-1:0] x_coord,
	input logic signed [COORD_WIDTH-1:0] y_coord,
	input logic signed [COORD_WIDTH-1:0] z_coord,
	input logic                          done,
	input logic signed [ANGLE_W-1:0]     azimuth,
	input logic        [POLAR_W-1:0]     polar_angle,
	input logic        [COORD_WIDTH-1:0] radius
);

	// the pipeline never refuses a transfer
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// the origin gives all zero outputs
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && x_coord == '0 && y_coord == '0 && z_coord == '0, LATENCY)
		|-> azimuth == '0 && polar_angle == '0 && radius == '0)
		else $error("origin result not zero");

	// a point on the z axis has zero azimuth
	a_z_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(start && x_coord == '0 && y_coord == '0, LATENCY)
		|-> azimuth == '0)
		else $error("z axis azimuth not zero");

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (.*);

// ===== tb/sv/tb_cartesian_to_spherical.sv =====
// testbench of the cartesian to spherical converter with a predicting scoreboard
module tb_cartesian_to_spherical import c2s_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 1030;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic [31:0] az;
		logic [30:0] pol;
		logic [31:0] rad;
	} sph_t;

	// expected spherical coordinates, computed from accepted points
	class sph_scoreboard;
		sph_t pending[$];
		int errors;
		int checked;

		function automatic longint floor_shr(longint v, int s);
			return v >>> s;
		endfunction

		function automatic longint unsigned inv_gain(longint a);
			longint unsigned ua, hi, lo;
			ua = (a < 0) ? 64'd0 : longint'(a);
			hi = ua >> 32;
			lo = ua & 64'hFFFF_FFFF;
			return 2 * hi * longint'(INV_GAIN) + ((lo * longint'(INV_GAIN)) >> 31);
		endfunction

		// vectoring cordic, returns final x and the angle of (x, y)
		function automatic longint vectoring(longint xi, longint yi, output logic [31:0] ang);
			longint xv, yv, t, dx, dy;
			logic [31:0] a;
			xv = xi;
			yv = yi;
			a = '0;
			if (xv < 0) begin
				t = xv;
				if (yv >= 0) begin
					xv = yv; yv = -t; a = QUARTER_TURN;
				end else begin
					xv = -yv; yv = t; a = NEG_QUARTER;
				end
			end
			for (int i = 0; i < CORDIC_STAGES; i++) begin
				dx = floor_shr(yv, i);
				dy = floor_shr(xv, i);
				if (yv >= 0) begin
					xv += dx; yv -= dy; a += atan_step(i);
				end else begin
					xv -= dx; yv += dy; a -= atan_step(i);
				end
			end
			ang = a;
			return xv;
		endfunction

		function automatic void note_point(logic signed [31:0] x, logic signed [31:0] y,
				logic signed [31:0] z);
			sph_t e;
			longint rho, x1, x2;
			longint unsigned rint, r;
			logic [31:0] az, pol;
			az = '0;
			rho = 0;
			if (x == 0 && y == 0 && z == 0) begin
				e.az = '0; e.pol = '0; e.rad = '0;
				pending.push_back(e);
				return;
			end
			if (x != 0 || y != 0) begin
				x1 = vectoring(longint'(x) <<< FRAC_SHIFT, longint'(y) <<< FRAC_SHIFT, az);
				rho = longint'(inv_gain(x1));
			end
			x2 = vectoring(longint'(z) <<< FRAC_SHIFT, rho, pol);
			rint = inv_gain(x2);
			r = (rint + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
			if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
			// polar overshoot clamps
			if (pol >= NEG_QUARTER) pol = '0;
			else if (pol >= HALF_TURN) pol = 32'h7FFF_FFFF;
			e.az = az;
			e.pol = pol[30:0];
			e.rad = r[31:0];
			pending.push_back(e);
		endfunction

		function automatic void check_result(logic [31:0] az, logic [30:0] pol, logic [31:0] rad);
			sph_t e;
			if (pending.size() == 0) begin
				$error("result with no point outstanding");
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (az !== e.az) begin
				$error("azimuth expected %h actual %h", e.az, az); errors++;
			end
			if (pol !== e.pol) begin
				$error("polar_angle expected %h actual %h", e.pol, pol); errors++;
			end
			if (rad !== e.rad) begin
				$error("radius expected %h actual %h", e.rad, rad); errors++;
			end
		endfunction
	endclass

	logic clk, arst_n, start, busy, done;
	logic signed [31:0] x_coord, y_coord, z_coord, azimuth;
	logic [30:0] polar_angle;
	logic [31:0] radius;
	longint cycles;
	sph_scoreboard sb;

	cartesian_to_spherical uut (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// result check and watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done) sb.check_result(azimuth, polar_angle, radius);
		if (cycles > CYCLE_LIMIT) begin
			$display("[cartesian_to_spherical] ERROR");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return $urandom_range(0, 8) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
			2: return 32'(signed'($urandom_range(0, 2000)) - 1000);
			3: return 32'd0;
			4: return 32'(signed'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000);
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	// one point transfer, with an optional gap before it
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		x_coord <= x; y_coord <= y; z_coord <= z;
		do @(posedge clk); while (busy);
		sb.note_point(x, y, z);
		@(negedge clk);
	endtask

	function automatic int rand_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 90);
	endfunction

	initial begin
		logic [31:0] d [0:5];
		int wait_cycles;
		sb = new();
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		x_coord = '0; y_coord = '0; z_coord = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: origin, axes, extremes, quadrants
		d = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1};
		send_point(0, 0, 0, 0);
		send_point(0, 0, 32'h0001_0000, 0);
		send_point(0, 0, 32'hFFFF_0000, 0);
		send_point(32'hFFFF_0000, 0, 0, 0);
		send_point(32'hFFFF_0000, 32'hFFFF_FFFF, 0, 1);
		send_point(32'hFFFF_0000, 32'h1, 0, 0);
		send_point(0, 32'h0001_0000, 0, 0);
		send_point(0, 32'hFFFF_0000, 0, 0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 2);
		send_point(32'h8000_0000, 0, 0, 0);
		send_point(0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_point(32'h1, 0, 32'h8000_0000, 0);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		for (int i = 0; i < 8; i++)
			send_point(d[$urandom_range(0, 5)], d[$urandom_range(0, 5)],
				d[$urandom_range(0, 5)], 0);

		// hold off until the pipeline has drained
		start <= 1'b0;
		wait_cycles = 0;
		while (sb.pending.size() != 0 && wait_cycles < 10 * LATENCY) begin
			@(negedge clk);
			wait_cycles++;
		end

		// random points with bursts and gaps
		for (int i = 0; i < N_RANDOM; i++)
			send_point(rand_coord(), rand_coord(), rand_coord(),
				($urandom_range(0, 3) == 0) ? 0 : rand_gap());
		start <= 1'b0;

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);

		$display("checked %0d conversions: origin, axes, coordinate extremes and random points",
			sb.checked);
		$display("input gaps from none to long, with one full drain");
		if (sb.errors == 0) $display("[cartesian_to_spherical] OK");
		else $display("[cartesian_to_spherical] ERROR");
		$finish;
	end
endmodule

// ===== cartesian_to_spherical.f =====
sv/c2s_pkg.sv
sv/cartesian_to_spherical.sv
sv/c2s_checker.sv
tb/sv/tb_cartesian_to_spherical.sv
